/* design/frss_pkg.sv */
// Shared types, register codes and floating-point helpers for the row sum block.
// Used by every module of the design; depends on nothing.
package frss_pkg;

  localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] F32_ONE  = 32'h3F80_0000;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH   = 2'd0,
    REG_ROW_COUNT    = 2'd1,
    REG_SCALE_VALUE  = 2'd2,
    REG_SCALE_ENABLE = 2'd3
  } cfg_reg_t;

  // One finished row moving down the pipeline.
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [63:0] value;
  } row_t;

  // Scale stage: partial products of the binary64 by binary32 multiply.
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        direct;
    logic        sign;
    logic [63:0] dval;
    logic [10:0] ea;
    logic [7:0]  eb;
    logic [64:0] pp0;
    logic [64:0] pp1;
  } mul_part_t;

  function automatic logic [127:0] shr_sticky128(input logic [127:0] v, input logic [7:0] n);
    logic [127:0] t;
    logic [127:0] mask;
    t    = v >> n;
    mask = ~({128{1'b1}} << n);
    return {t[127:1], t[0] | (|(v & mask))};
  endfunction

  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] n;
    n = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) n = 5'(22 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    n = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (v[i]) n = 6'(55 - i);
    end
    return n;
  endfunction

  function automatic logic [6:0] lzc77(input logic [76:0] v);
    logic [6:0] n;
    n = 7'd77;
    for (int i = 0; i < 77; i++) begin
      if (v[i]) n = 7'(76 - i);
    end
    return n;
  endfunction

  // Exact binary32 to binary64 conversion.
  function automatic logic [63:0] f32_widen(input logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] f;
    logic [22:0] fs;
    logic [4:0]  lz;
    e = x[30:23];
    f = x[22:0];
    if (e == 8'hFF) return {x[31], 11'h7FF, f, 29'd0};
    if (e == 8'd0) begin
      if (f == 23'd0) return {x[31], 63'd0};
      lz = lzc23(f);
      fs = f << (lz + 5'd1);
      return {x[31], 11'd896 - {6'd0, lz}, fs, 29'd0};
    end
    return {x[31], {3'd0, e} + 11'd896, f, 29'd0};
  endfunction

  // binary64 add, round to nearest even.
  function automatic logic [63:0] f64_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0]  x;
    logic [63:0]  y;
    logic         nan_a;
    logic         nan_b;
    logic         inf_a;
    logic         inf_b;
    logic         sub;
    logic         inc;
    logic [10:0]  ex;
    logic [10:0]  ey;
    logic [10:0]  d;
    logic [10:0]  e;
    logic [10:0]  ef;
    logic [52:0]  mx;
    logic [52:0]  my;
    logic [55:0]  ax;
    logic [55:0]  ay;
    logic [55:0]  nm;
    logic [56:0]  sum;
    logic [5:0]   lz;
    logic [5:0]   sh;
    logic [127:0] w;
    logic [62:0]  pk;
    nan_a = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    nan_b = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    inf_a = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    inf_b = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    if (nan_a || nan_b) return F64_QNAN;
    if (inf_a && inf_b && (a[63] != b[63])) return F64_QNAN;
    if (inf_a) return a;
    if (inf_b) return b;
    if (a[62:0] >= b[62:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    ey = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
    mx = {x[62:52] != 11'd0, x[51:0]};
    my = {y[62:52] != 11'd0, y[51:0]};
    d  = ex - ey;
    ax = {mx, 3'b000};
    if (d > 11'd55) begin
      ay = {55'd0, |my};
    end else begin
      w  = shr_sticky128(128'({my, 3'b000}), 8'(d));
      ay = w[55:0];
    end
    sub = x[63] ^ y[63];
    sum = sub ? ({1'b0, ax} - {1'b0, ay}) : ({1'b0, ax} + {1'b0, ay});
    // exact cancellation gives +0; two negative zeros stay negative
    if (sum == 57'd0) return {~sub & x[63], 63'd0};
    if (sum[56]) begin
      nm = {sum[56:2], sum[1] | sum[0]};
      e  = ex + 11'd1;
    end else begin
      lz = lzc56(sum[55:0]);
      sh = ({5'd0, lz} < ex) ? lz : 6'(ex - 11'd1);
      nm = sum[55:0] << sh;
      e  = ex - {5'd0, sh};
    end
    if (e == 11'h7FF) return {x[63], 11'h7FF, 52'd0};
    ef  = nm[55] ? e : 11'd0;
    pk  = {ef, nm[54:3]};
    inc = nm[2] & (nm[3] | nm[1] | nm[0]);
    return {x[63], pk + 63'(inc)};
  endfunction

  // Normalize and round a 77-bit product of finite nonzero operands to binary64.
  function automatic logic [63:0] f64_mul_finish(input logic sign, input logic [10:0] ea,
                                                 input logic [7:0] eb, input logic [76:0] p);
    logic [6:0]          lz;
    logic signed [13:0]  e0;
    logic signed [13:0]  e;
    logic [76:0]         m;
    logic [10:0]         ef;
    logic [62:0]         pk;
    logic                inc;
    logic [127:0]        w;
    lz = lzc77(p);
    e0 = $signed({3'd0, ea}) + $signed({6'd0, eb}) - 14'sd126;
    e  = e0 - $signed({7'd0, lz});
    if (e >= 14'sd2047) return {sign, 11'h7FF, 52'd0};
    if (e >= 14'sd1) begin
      m  = p << lz;
      ef = e[10:0];
    end else begin
      ef = 11'd0;
      if (e0 >= 14'sd1) begin
        m = p << 7'(e0 - 14'sd1);
      end else if (e0 <= -14'sd76) begin
        m = {76'd0, |p};
      end else begin
        w = shr_sticky128(128'(p), 8'(14'sd1 - e0));
        m = w[76:0];
      end
    end
    pk  = {ef, m[75:24]};
    inc = m[23] & (m[24] | (|m[22:0]));
    return {sign, pk + 63'(inc)};
  endfunction

  // binary64 to binary32, round to nearest even, NaN made canonical.
  function automatic logic [31:0] f64_narrow(input logic [63:0] d);
    logic [10:0]         ex;
    logic [51:0]         f;
    logic signed [11:0]  e32;
    logic [30:0]         pk;
    logic                inc;
    logic [127:0]        w;
    logic [52:0]         m;
    ex = d[62:52];
    f  = d[51:0];
    if (ex == 11'h7FF) return (f != 52'd0) ? F32_QNAN : {d[63], 8'hFF, 23'd0};
    if (ex == 11'd0) return {d[63], 31'd0};
    e32 = $signed({1'b0, ex}) - 12'sd896;
    if (e32 >= 12'sd255) return {d[63], 8'hFF, 23'd0};
    if (e32 >= 12'sd1) begin
      pk  = {e32[7:0], f[51:29]};
      inc = f[28] & (f[29] | (|f[27:0]));
    end else begin
      if (e32 <= -12'sd52) begin
        m = 53'd1;
      end else begin
        w = shr_sticky128(128'({1'b1, f}), 8'(12'sd1 - e32));
        m = w[52:0];
      end
      pk  = 31'(m[52:29]);
      inc = m[28] & (m[29] | (|m[27:0]));
    end
    return {d[63], pk + 31'(inc)};
  endfunction

endpackage

/* design/frss_accum.sv */
// Input register, binary64 row accumulator and element/row counters.
// Depends on frss_pkg.
module frss_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              element_valid,
  input  logic [31:0]       element_bits,
  input  logic [16:0]       len_eff,
  input  logic [16:0]       rows_eff,
  output frss_pkg::row_t    row_out
);
  import frss_pkg::*;

  logic        el_valid;
  logic [63:0] el_value;
  logic [63:0] accumulator;
  logic [16:0] element_counter;
  logic [16:0] row_counter;

  logic [63:0] sum_new;
  logic [17:0] elem_inc;
  logic [17:0] row_inc;
  logic        row_end;
  logic        batch_end;

  assign sum_new   = f64_add(accumulator, el_value);
  assign elem_inc  = {1'b0, element_counter} + 18'd1;
  assign row_inc   = {1'b0, row_counter} + 18'd1;
  assign row_end   = elem_inc >= {1'b0, len_eff};
  assign batch_end = row_inc >= {1'b0, rows_eff};

  // widen on the way in so the loop holds only the adder
  always_ff @(posedge clk) begin
    if (adv) el_value <= f32_widen(element_bits);
    if (rst) begin
      el_valid <= 1'b0;
    end else if (adv) begin
      el_valid <= element_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= 64'd0;
      element_counter <= 17'd0;
      row_counter     <= 17'd0;
    end else if (adv && el_valid) begin
      if (row_end) begin
        accumulator     <= 64'd0;
        element_counter <= 17'd0;
        row_counter     <= batch_end ? 17'd0 : row_inc[16:0];
      end else begin
        accumulator     <= sum_new;
        element_counter <= elem_inc[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_out.value <= sum_new;
      row_out.last  <= batch_end;
    end
    if (rst) begin
      row_out.valid <= 1'b0;
    end else if (adv) begin
      row_out.valid <= el_valid && row_end;
    end
  end

endmodule

/* design/frss_scale.sv */
// Optional scale multiply: partial products, then normalize and round to binary64.
// Depends on frss_pkg.
module frss_scale (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [31:0]       scale_value,
  input  logic              scale_enable,
  input  frss_pkg::row_t    row_in,
  output frss_pkg::row_t    row_out
);
  import frss_pkg::*;

  mul_part_t   part;
  mul_part_t   part_next;
  logic [63:0] va;
  logic        nan_a;
  logic        inf_a;
  logic        zero_a;
  logic        nan_b;
  logic        inf_b;
  logic        zero_b;
  logic [52:0] ma;
  logic [23:0] mb;
  logic [76:0] prod;

  assign va     = row_in.value;
  assign nan_a  = (va[62:52] == 11'h7FF) && (va[51:0] != 52'd0);
  assign inf_a  = (va[62:52] == 11'h7FF) && (va[51:0] == 52'd0);
  assign zero_a = va[62:0] == 63'd0;
  assign nan_b  = (scale_value[30:23] == 8'hFF) && (scale_value[22:0] != 23'd0);
  assign inf_b  = (scale_value[30:23] == 8'hFF) && (scale_value[22:0] == 23'd0);
  assign zero_b = scale_value[30:0] == 31'd0;
  assign ma     = {va[62:52] != 11'd0, va[51:0]};
  assign mb     = {scale_value[30:23] != 8'd0, scale_value[22:0]};

  always_comb begin
    part_next       = '0;
    part_next.valid = row_in.valid;
    part_next.last  = row_in.last;
    part_next.sign  = va[63] ^ scale_value[31];
    part_next.ea    = (va[62:52] == 11'd0) ? 11'd1 : va[62:52];
    part_next.eb    = (scale_value[30:23] == 8'd0) ? 8'd1 : scale_value[30:23];
    part_next.pp0   = {12'd0, ma} * {53'd0, mb[11:0]};
    part_next.pp1   = {12'd0, ma} * {53'd0, mb[23:12]};
    part_next.direct = 1'b1;
    if (!scale_enable) begin
      part_next.dval = va;
    end else if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
      part_next.dval = F64_QNAN;
    end else if (inf_a || inf_b) begin
      part_next.dval = {part_next.sign, 11'h7FF, 52'd0};
    end else if (zero_a || zero_b) begin
      part_next.dval = {part_next.sign, 63'd0};
    end else begin
      part_next.dval   = va;
      part_next.direct = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part.valid <= 1'b0;
    end else if (adv) begin
      part <= part_next;
    end
  end

  assign prod = 77'(part.pp0) + (77'(part.pp1) << 12);

  always_ff @(posedge clk) begin
    if (adv) begin
      row_out.last  <= part.last;
      row_out.value <= part.direct ? part.dval
                                   : f64_mul_finish(part.sign, part.ea, part.eb, prod);
    end
    if (rst) begin
      row_out.valid <= 1'b0;
    end else if (adv) begin
      row_out.valid <= part.valid;
    end
  end

endmodule

/* design/frss_narrow.sv */
// Rounding to binary32 and the result register.
// Depends on frss_pkg.
module frss_narrow (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  frss_pkg::row_t    row_in,
  output logic              result_valid,
  output logic [31:0]       sum_bits,
  output logic              last_row
);
  import frss_pkg::*;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_bits <= f64_narrow(row_in.value);
      last_row <= row_in.last;
    end
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= row_in.valid;
    end
  end

endmodule

/* design/float_row_sum_scale_top.sv */
// Top level of the binary32 row sum with optional scale: config registers and pipeline.
// Depends on frss_pkg, frss_accum, frss_scale and frss_narrow.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+-------------------------
//   element   | element_valid, element_stall | element_bits
//   result    | result_valid, result_stall   | sum_bits, last_row
//   config    | cfg_write                    | cfg_index, cfg_data
//
// One element is taken every cycle unless element_stall is high; the accumulator add is combinational.
// After its last element is transferred, a row's result passes the input register,
// accumulator output, two multiply stages and rounding register.
// Synchronous reset clears the accumulator, counters and valids and returns the
// config registers to their defaults.
// A stalled result freezes the whole pipeline and raises element_stall.
module float_row_sum_scale_top #(
  parameter int MAX_ROW_LENGTH = 65536,
  parameter int MAX_ROWS       = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        element_valid,
  output logic        element_stall,
  input  logic [31:0] element_bits,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] sum_bits,
  output logic        last_row,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import frss_pkg::*;

  localparam logic [24:0] MAX_LEN  = 25'(MAX_ROW_LENGTH);
  localparam logic [24:0] MAX_ROWC = 25'(MAX_ROWS);

  logic [16:0] row_length;
  logic [16:0] row_count;
  logic [31:0] scale_value;
  logic        scale_enable;
  logic [16:0] len_eff;
  logic [16:0] rows_eff;
  logic        adv;
  row_t        acc_row;
  row_t        scaled_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= 17'd1;
      row_count    <= 17'd1;
      scale_value  <= F32_ONE;
      scale_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_LENGTH:   row_length   <= cfg_data[16:0];
        REG_ROW_COUNT:    row_count    <= cfg_data[16:0];
        REG_SCALE_VALUE:  scale_value  <= cfg_data;
        REG_SCALE_ENABLE: scale_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (row_length == 17'd0) len_eff = 17'd1;
    else if ({8'd0, row_length} > MAX_LEN) len_eff = MAX_LEN[16:0];
    else len_eff = row_length;
    if (row_count == 17'd0) rows_eff = 17'd1;
    else if ({8'd0, row_count} > MAX_ROWC) rows_eff = MAX_ROWC[16:0];
    else rows_eff = row_count;
  end

  assign adv           = !(result_valid && result_stall);
  assign element_stall = !adv;

  frss_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .element_valid (element_valid),
    .element_bits  (element_bits),
    .len_eff       (len_eff),
    .rows_eff      (rows_eff),
    .row_out       (acc_row)
  );

  frss_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .scale_value  (scale_value),
    .scale_enable (scale_enable),
    .row_in       (acc_row),
    .row_out      (scaled_row)
  );

  frss_narrow u_narrow (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .row_in       (scaled_row),
    .result_valid (result_valid),
    .sum_bits     (sum_bits),
    .last_row     (last_row)
  );

  a_nan_canonical: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sum_bits[30:23] == 8'hFF) && (sum_bits[22:0] != 23'd0)
      |-> sum_bits == F32_QNAN)
    else $error("non-canonical NaN in result");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for float_row_sum_scale_top: streams binary32 elements,
// predicts every row sum in a scoreboard and checks each result transfer.
// Depends on frss_pkg and the design top level.
module testbench;
  import frss_pkg::*;

  typedef struct {
    logic [31:0] sum;
    logic        last;
  } row_result_t;

  // Predicts row sums; binary64 adds and multiplies use the simulator's real type.
  class row_sum_board;
    logic [16:0]  row_length;
    logic [16:0]  row_count;
    logic [31:0]  scale_value;
    logic         scale_enable;
    real          acc;
    int unsigned  elem_cnt;
    int unsigned  row_cnt;
    row_result_t  expected_rows[$];
    int           errors;

    function new();
      row_length = 17'd1;
      row_count = 17'd1;
      scale_value = F32_ONE;
      scale_enable = 1'b0;
      acc = 0.0;
      elem_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_ROW_LENGTH:   row_length = data[16:0];
        REG_ROW_COUNT:    row_count = data[16:0];
        REG_SCALE_VALUE:  scale_value = data;
        REG_SCALE_ENABLE: scale_enable = data[0];
        default: ;
      endcase
    endfunction

    static function real to_double(logic [31:0] x);
      logic [10:0] e64;
      logic [22:0] f;
      f = x[22:0];
      if (x[30:23] == 8'hFF) return $bitstoreal({x[31], 11'h7FF, f, 29'd0});
      if (x[30:23] == 8'd0) begin
        if (f == 23'd0) return $bitstoreal({x[31], 63'd0});
        e64 = 11'd897;
        // normalize the subnormal fraction
        while (!f[22]) begin
          f = f << 1;
          e64 = e64 - 11'd1;
        end
        f = f << 1;
        return $bitstoreal({x[31], e64 - 11'd1, f, 29'd0});
      end
      return $bitstoreal({x[31], 3'd0 + x[30:23] + 11'd896, f, 29'd0});
    endfunction

    static function logic [31:0] to_single(real r);
      logic [63:0] d;
      logic [52:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [31:0] pk;
      int          e32;
      int          sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? F32_QNAN : {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e32 = int'(d[62:52]) - 896;
      if (e32 >= 255) return {d[63], 8'hFF, 23'd0};
      m = {1'b1, d[51:0]};
      sh = (e32 >= 1) ? 29 : 29 + 1 - e32;
      if (sh >= 55) return {d[63], 31'd0};
      q = 64'(m) >> sh;
      rem = 64'(m) & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      pk = (e32 >= 1) ? 32'((e32 - 1) << 23) + q[31:0] : q[31:0];
      if (rem > half || (rem == half && q[0])) pk = pk + 32'd1;
      return {d[63], pk[30:0]};
    endfunction

    function void note_element(logic [31:0] bits);
      int unsigned len;
      int unsigned rows;
      real         s;
      row_result_t res;
      len = (row_length == 0) ? 1 : (row_length > 65536) ? 65536 : row_length;
      rows = (row_count == 0) ? 1 : (row_count > 65536) ? 65536 : row_count;
      acc = acc + to_double(bits);
      elem_cnt++;
      if (elem_cnt < len) return;
      s = acc;
      if (scale_enable) s = s * to_double(scale_value);
      row_cnt++;
      res.last = (row_cnt >= rows);
      if (res.last) row_cnt = 0;
      acc = 0.0;
      elem_cnt = 0;
      res.sum = to_single(s);
      expected_rows.push_back(res);
    endfunction

    function void check_result(logic [31:0] sum, logic last);
      row_result_t exp_row;
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result sum=%h last=%b", sum, last);
        return;
      end
      exp_row = expected_rows.pop_front();
      if (sum !== exp_row.sum || last !== exp_row.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: sum exp %h got %h, last exp %b got %b",
                   exp_row.sum, sum, exp_row.last, last);
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        element_valid;
  logic        element_stall;
  logic [31:0] element_bits;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] sum_bits;
  logic        last_row;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  row_sum_board sb;
  int           idle_pct;
  int           stall_pct;
  int           quiet_cycles;

  float_row_sum_scale_top dut (
    .clk(clk), .rst(rst),
    .element_valid(element_valid), .element_stall(element_stall),
    .element_bits(element_bits),
    .result_valid(result_valid), .result_stall(result_stall),
    .sum_bits(sum_bits), .last_row(last_row),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(sum_bits, last_row);
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (result_valid && !result_stall) || (element_valid && !element_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(logic [31:0] bits);
    while ($urandom_range(99) < idle_pct) begin
      element_valid <= 1'b0;
      @(posedge clk);
    end
    element_valid <= 1'b1;
    element_bits <= bits;
    do @(posedge clk); while (element_stall);
    sb.note_element(bits);
  endtask

  // Drop valid, wait for every expected row, then let the pipeline settle.
  task automatic drain();
    int saved;
    element_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    saved = stall_pct;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    stall_pct = saved;
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function automatic logic [31:0] rand_element();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return {r[31], 31'd0};
      1: return {r[31], 8'hFF, 23'd0};
      2: return {r[31], 8'hFF, r[22:1], 1'b1};
      3: return {r[31], 8'h00, r[22:0]};
      4: return {r[31], 8'hFE, 23'h7FFFFF};
      5, 6, 7: return {r[31], 8'($urandom_range(120, 135)), r[22:0]};
      8: return {r[31], 8'($urandom_range(250, 254)), r[22:0]};
      default: return r;
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall, bit pause);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        drain();
        write_cfg(REG_ROW_LENGTH, ($urandom_range(9) == 0) ? 32'($urandom_range(40))
                                                           : 32'($urandom_range(1, 6)));
        write_cfg(REG_ROW_COUNT, 32'($urandom_range(0, 5)));
        write_cfg(REG_SCALE_VALUE, rand_element());
        write_cfg(REG_SCALE_ENABLE, 32'($urandom_range(1)));
      end
      if (pause && i == n / 2) drain();
      send(rand_element());
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    element_valid <= 1'b0;
    element_bits <= 32'd0;
    cfg_write <= 1'b0;
    cfg_index <= REG_ROW_LENGTH;
    cfg_data <= 32'd0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset config: one element per row, every row last.
    send(32'h0000_0000);
    send(32'h8000_0000);
    send(32'h3F80_0000);
    send(32'h7F80_0000);
    send(32'hFF80_0000);
    send(32'h7FBF_FFFF);
    send(32'h0000_0001);
    send(32'h7F7F_FFFF);
    drain();
    write_cfg(REG_ROW_LENGTH, 32'd2);
    write_cfg(REG_ROW_COUNT, 32'd3);
    send(32'h7F80_0000);
    send(32'hFF80_0000);
    send(32'h7F7F_FFFF);
    send(32'h7F7F_FFFF);
    send(32'h3F80_0000);
    send(32'h3380_0000);
    drain();
    write_cfg(REG_SCALE_ENABLE, 32'd1);
    write_cfg(REG_SCALE_VALUE, 32'h0000_0000);
    send(32'h7F80_0000);
    send(32'h0000_0000);
    drain();
    write_cfg(REG_SCALE_VALUE, 32'hFFC1_2345);
    write_cfg(REG_ROW_LENGTH, 32'd0);
    write_cfg(REG_ROW_COUNT, 32'd0);
    send(32'h4000_0000);
    drain();
    write_cfg(REG_SCALE_VALUE, 32'h0080_0000);
    send(32'h0080_0000);
    drain();
    // Shorten a row midway: it ends on the next element.
    write_cfg(REG_SCALE_ENABLE, 32'd0);
    write_cfg(REG_ROW_LENGTH, 32'd8);
    write_cfg(REG_ROW_COUNT, 32'h1_FFFF);
    repeat (5) send(rand_element());
    drain();
    write_cfg(REG_ROW_LENGTH, 32'd3);
    send(32'h3F80_0000);
    drain();
    // Lengths above the maximum act as the maximum: no row ends, then shorten it.
    write_cfg(REG_ROW_LENGTH, 32'h1_FFFF);
    write_cfg(REG_ROW_COUNT, 32'h1_0000);
    for (int i = 0; i < 20; i++) send({$urandom_range(1), 8'($urandom_range(100, 140)),
                                       23'($urandom)});
    drain();
    write_cfg(REG_ROW_LENGTH, 32'd4);
    send(32'h3F80_0000);
    drain();
    write_cfg(REG_ROW_LENGTH, 32'h1_0000);
    write_cfg(REG_ROW_COUNT, 32'd1);

    random_phase(125, 0, 0, 1'b0);
    random_phase(125, 65, 0, 1'b1);
    random_phase(125, 0, 65, 1'b0);
    random_phase(125, 30, 30, 1'b0);
    drain();
    write_cfg(REG_ROW_LENGTH, 32'd1);
    idle_pct = 0;
    stall_pct = 50;
    repeat (30) send(rand_element());
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
